FILE: hdl/rqar_pkg.sv
// Shared types and constants for the ready queue append/remove unit.
package rqar_pkg;

	localparam int STATUS_W = 2;
	localparam int TASK_W   = 8;
	localparam int LEN_W    = 5;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} rqar_status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_SHIFT,
		SEQ_DONE
	} rqar_seq_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TASK_W-1:0]   head_task;
		logic                head_valid;
		logic [LEN_W-1:0]    queue_length;
	} rqar_result_t;

endpackage

FILE: hdl/rqar_if.sv
// Valid/ready channel interfaces for request and response words.
interface rqar_req_if
	import rqar_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [TASK_W-1:0] task_id;

	modport source (output valid, output operation, output task_id, input ready);
	modport sink   (input valid, input operation, input task_id, output ready);
endinterface

interface rqar_rsp_if
	import rqar_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [TASK_W-1:0]   head_task;
	logic                head_valid;
	logic [LEN_W-1:0]    queue_length;

	modport source (output valid, output status, output head_task, output head_valid,
		output queue_length, input ready);
	modport sink   (input valid, input status, input head_task, input head_valid,
		input queue_length, output ready);
endinterface

FILE: hdl/rqar_mem.sv
// Queue entry store: one write port, one registered read port.
module rqar_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/rqar_seq.sv
// Sequencer with the shared compare/index unit: appends to, scans and compacts the queue.
module rqar_seq
	import rqar_pkg::*;
#(
	parameter int QUEUE_DEPTH  = 16,
	parameter int TASK_ID_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            op,
	input  logic [TASK_ID_BITS-1:0]         task_in,
	input  logic                            out_free,
	output logic                            idle,
	output logic                            res_valid,
	output rqar_result_t                    res,
	output logic                            mem_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0]  mem_waddr,
	output logic [TASK_ID_BITS-1:0]         mem_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0]  mem_raddr,
	input  logic [TASK_ID_BITS-1:0]         mem_rdata
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	rqar_seq_state_t         state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [CNT_W-1:0]        idx_q, idx_d;
	logic [TASK_ID_BITS-1:0] task_q, task_d;
	logic [TASK_ID_BITS-1:0] head_q, head_d;
	rqar_status_t            status_q, status_d;

	logic [CNT_W:0] idx_p1, idx_p2, cnt_x;
	logic           full, match;

	assign idx_p1 = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign idx_p2 = {1'b0, idx_q} + (CNT_W+1)'(2);
	assign cnt_x  = {1'b0, count_q};
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign match  = (mem_rdata == task_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		task_q   <= task_d;
		head_q   <= head_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		task_d    = task_q;
		head_d    = head_q;
		status_d  = status_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = task_in;
		mem_raddr = '0;
		case (state_q)
			SEQ_IDLE: begin
				idle = 1'b1;
				if (start) begin
					task_d   = task_in;
					status_d = STATUS_DONE;
					idx_d    = '0;
					if (op == OP_APPEND) begin
						state_d = SEQ_DONE;
						if (full) begin
							status_d = STATUS_FULL;
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
							if (count_q == '0) begin
								head_d = task_in;
							end
						end
					end else if (count_q == '0) begin
						status_d = STATUS_NOT_FOUND;
						state_d  = SEQ_DONE;
					end else begin
						state_d = SEQ_SCAN;
					end
				end
			end
			SEQ_SCAN: begin
				// read of the next entry goes out while this one is compared
				mem_raddr = idx_p1[IDX_W-1:0];
				if (match) begin
					if (idx_p1 < cnt_x) begin
						state_d = SEQ_SHIFT;
					end else begin
						count_d = count_q - CNT_W'(1);
						state_d = SEQ_DONE;
					end
				end else if (idx_p1 < cnt_x) begin
					idx_d = idx_p1[CNT_W-1:0];
				end else begin
					status_d = STATUS_NOT_FOUND;
					state_d  = SEQ_DONE;
				end
			end
			SEQ_SHIFT: begin
				// entry idx+1 moves up to idx; entry idx+2 is fetched
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0];
				mem_wdata = mem_rdata;
				mem_raddr = idx_p2[IDX_W-1:0];
				idx_d     = idx_p1[CNT_W-1:0];
				if (idx_q == '0) begin
					head_d = mem_rdata;
				end
				if (idx_p2 >= cnt_x) begin
					count_d = count_q - CNT_W'(1);
					state_d = SEQ_DONE;
				end
			end
			SEQ_DONE: begin
				res_valid = 1'b1;
				if (out_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	assign res.status       = status_q;
	assign res.head_valid   = (count_q != '0);
	assign res.head_task    = (count_q != '0) ? TASK_W'(head_q) : '0;
	assign res.queue_length = LEN_W'(count_q);

endmodule

FILE: hdl/ready_queue_append_remove_unit.sv
// Top level of the ready queue append/remove unit.
//
// Ordered queue of up to QUEUE_DEPTH task identifiers. A request word with
// operation append puts task_id at the tail (status full if no room); with
// operation remove it deletes the entry nearest the head equal to task_id
// and closes the gap, keeping order (status not found otherwise, also on an
// empty queue). Each request gives one response word with status, head task,
// head-valid flag and the queue length after the step. An append writes
// the tail when it is accepted; a remove compares the entries from the
// head one by one until a match or the end, then shifts each later entry
// up one place. This work runs on the single entry store, which gives
// one registered read and one write per cycle, and the one comparator
// that walks it. The unit takes one request at a time; a new request is
// accepted once the previous one has passed its response word to the output
// register, even if that word is still waiting there.
module ready_queue_append_remove_unit
	import rqar_pkg::*;
#(
	parameter int QUEUE_DEPTH  = 16,
	parameter int TASK_ID_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	rqar_req_if.sink   req,
	rqar_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic                    start, idle, res_valid, out_free;
	rqar_result_t            res;
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr, mem_raddr;
	logic [TASK_ID_BITS-1:0] mem_wdata, mem_rdata;
	logic [TASK_ID_BITS-1:0] task_in;

	rqar_result_t rsp_q;
	logic         rsp_valid_q;

	// identifiers wider than the store are cut, narrower ones zero-filled
	assign task_in   = TASK_ID_BITS'(req.task_id);
	assign req.ready = idle;
	assign start     = req.valid && idle;
	assign out_free  = !rsp_valid_q || rsp.ready;

	rqar_mem #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (TASK_ID_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rqar_seq #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (req.operation),
		.task_in   (task_in),
		.out_free  (out_free),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// response register: holds the word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.head_task    = rsp_q.head_task;
	assign rsp.head_valid   = rsp_q.head_valid;
	assign rsp.queue_length = rsp_q.queue_length;

endmodule

FILE: hdl/rqar_checker.sv
// Port-level assertions for the ready queue unit, bound to the top level.
module rqar_checker
	import rqar_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [TASK_W-1:0]   rsp_head_task,
	input logic                rsp_head_valid,
	input logic [LEN_W-1:0]    rsp_queue_length
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_queue_length))
		else $error("response word changed while stalled");

	a_head_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_head_valid == (rsp_queue_length != '0))
			&& (rsp_head_valid || rsp_head_task == '0))
		else $error("head flag does not match queue length");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STATUS_FULL |->
			rsp_queue_length == LEN_W'(QUEUE_DEPTH))
		else $error("full reported on a queue that is not full");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (QUEUE_DEPTH > 31) || (int'(rsp_queue_length) <= QUEUE_DEPTH))
		else $error("queue length beyond depth");

endmodule

bind ready_queue_append_remove_unit rqar_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_rqar_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_head_task    (rsp.head_task),
	.rsp_head_valid   (rsp.head_valid),
	.rsp_queue_length (rsp.queue_length)
);

FILE: bench/tb.sv
// Self-checking bench for the ready queue append/remove unit.
module tb;
	import rqar_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	// Cycles with no handshake on either channel before the run is called hung.
	localparam int STALL_LIMIT  = 4000;
	// Long enough for a full-queue miss to finish, with a margin.
	localparam int DRAIN_CYCLES = 4 * (QUEUE_DEPTH + 2);
	localparam int SMALL_IDS    = 8;

	logic clk;
	logic arst_n;

	rqar_req_if req_ch ();
	rqar_rsp_if rsp_ch ();

	ready_queue_append_remove_unit #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_ID_BITS(TASK_W)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the ready queue, advanced at each accepted request word.
	logic [TASK_W-1:0] ready_tasks [QUEUE_DEPTH];
	int                ready_count;

	// Expected response words, oldest first.
	rqar_result_t pending_views[$];

	// Idling percentages for the two sides, changed between phases.
	int send_idle_pct;
	int recv_stall_pct;

	int mismatches;
	int words_sent;
	int words_checked;
	int fulls_seen;
	int misses_seen;
	int deepest_queue;
	int quiet_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one request to the shadow queue and return the response word it
	// should produce. Remove takes the match nearest the head and closes the
	// gap, so the order of the remaining tasks is kept.
	function automatic rqar_result_t queue_after_request(input logic op,
			input logic [TASK_W-1:0] id);
		rqar_result_t view;
		int           hit;
		hit = -1;
		view.status = STATUS_DONE;
		if (op == OP_APPEND) begin
			if (ready_count >= QUEUE_DEPTH) begin
				view.status = STATUS_FULL;
			end else begin
				ready_tasks[ready_count] = id;
				ready_count++;
			end
		end else begin
			for (int i = 0; i < ready_count; i++) begin
				if (hit < 0 && ready_tasks[i] == id)
					hit = i;
			end
			if (hit < 0) begin
				// also covers a remove from an empty queue
				view.status = STATUS_NOT_FOUND;
			end else begin
				for (int i = hit; i < ready_count - 1; i++)
					ready_tasks[i] = ready_tasks[i + 1];
				ready_count--;
			end
		end
		// empty queue reports head task 0 with the flag low
		view.head_valid   = (ready_count > 0);
		view.head_task    = (ready_count > 0) ? ready_tasks[0] : '0;
		view.queue_length = LEN_W'(ready_count);
		return view;
	endfunction

	// Offer one request word, with random idle cycles ahead of it, and hold it
	// until the unit takes it. Ready is sampled at the edge, before any flop
	// of the unit updates, so acceptance is read without a race.
	task automatic offer_request(input logic op, input logic [TASK_W-1:0] id);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.task_id   <= id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_views.push_back(queue_after_request(op, id));
		words_sent++;
		if (ready_count > deepest_queue)
			deepest_queue = ready_count;
	endtask

	// Removes on an empty queue, at both ends of the identifier range.
	task automatic test_empty_queue();
		offer_request(OP_REMOVE, 8'h00);
		offer_request(OP_REMOVE, 8'hFF);
	endtask

	// Fill to the brim with a duplicate in the middle, then one append too many.
	task automatic test_fill_and_overflow();
		logic [TASK_W-1:0] opening [5] = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'hAA};
		foreach (opening[i])
			offer_request(OP_APPEND, opening[i]);
		for (int i = 1; i <= QUEUE_DEPTH - 5; i++)
			offer_request(OP_APPEND, TASK_W'(i));
		offer_request(OP_APPEND, 8'h7F);
	endtask

	// Removal from the middle (first of a duplicate pair), near the head,
	// the tail, a miss on a full-ish queue, the head itself, and then the second of the pair.
	task automatic test_ordered_removal();
		offer_request(OP_REMOVE, 8'hAA);
		offer_request(OP_REMOVE, 8'hFF);
		offer_request(OP_REMOVE, TASK_W'(QUEUE_DEPTH - 5));
		offer_request(OP_REMOVE, 8'h33);
		offer_request(OP_REMOVE, 8'h00);
		offer_request(OP_REMOVE, 8'hAA);
	endtask

	// Random traffic steered by a wandering fill level. Most removes name a
	// task that is queued; the rest draw a random identifier and may miss.
	// Appends draw from a small set half the time so duplicates are common.
	// A fill level past the depth keeps appending into a full queue.
	task automatic test_random_traffic(input int words, input int send_pct,
			input int stall_pct);
		int                fill_goal;
		logic              op;
		logic [TASK_W-1:0] id;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		fill_goal      = 0;
		for (int n = 0; n < words; n++) begin
			if (n % 40 == 0)
				fill_goal = $urandom_range(QUEUE_DEPTH + 2);
			if (ready_count < fill_goal)
				op = ($urandom_range(99) < 85) ? OP_APPEND : OP_REMOVE;
			else
				op = ($urandom_range(99) < 80) ? OP_REMOVE : OP_APPEND;
			if (fill_goal > QUEUE_DEPTH && $urandom_range(99) < 70)
				op = OP_APPEND;
			if (op == OP_REMOVE && ready_count > 0 && $urandom_range(99) < 80)
				id = ready_tasks[$urandom_range(ready_count - 1)];
			else if ($urandom_range(1))
				id = TASK_W'($urandom_range(SMALL_IDS - 1));
			else
				id = TASK_W'($urandom);
			offer_request(op, id);
		end
	endtask

	// Response side: check each accepted word against the oldest expectation,
	// then pick the ready level for the next cycle.
	always @(posedge clk) begin
		rqar_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_views.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response word: status %0d head %02h/%0b len %0d",
							rsp_ch.status, rsp_ch.head_task, rsp_ch.head_valid,
							rsp_ch.queue_length);
				end else begin
					want = pending_views.pop_front();
					words_checked++;
					if (want.status == STATUS_FULL)
						fulls_seen++;
					if (want.status == STATUS_NOT_FOUND)
						misses_seen++;
					if (rsp_ch.status !== want.status || rsp_ch.head_task !== want.head_task
							|| rsp_ch.head_valid !== want.head_valid
							|| rsp_ch.queue_length !== want.queue_length) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word %0d: want status %0d head %02h/%0b len %0d, got status %0d head %02h/%0b len %0d",
								words_checked, want.status, want.head_task, want.head_valid,
								want.queue_length, rsp_ch.status, rsp_ch.head_task,
								rsp_ch.head_valid, rsp_ch.queue_length);
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: too long without a handshake on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d words outstanding",
					quiet_cycles, pending_views.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_APPEND;
		req_ch.task_id   = '0;
		rsp_ch.ready     = 1'b0;
		ready_count      = 0;
		mismatches       = 0;
		words_sent       = 0;
		words_checked    = 0;
		fulls_seen       = 0;
		misses_seen      = 0;
		deepest_queue    = 0;
		quiet_cycles     = 0;
		send_idle_pct    = 24;
		recv_stall_pct   = 69;
		foreach (ready_tasks[i])
			ready_tasks[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_fill_and_overflow();
		test_ordered_removal();
		test_random_traffic(260, 24, 69);
		test_random_traffic(260, 69, 24);
		test_random_traffic(260, 0, 0);

		req_ch.valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request words sent, %0d responses checked, %0d mismatches",
			words_sent, words_checked, mismatches);
		$display("appends refused on a full queue: %0d, removes missed: %0d, deepest queue %0d",
			fulls_seen, misses_seen, deepest_queue);
		if (mismatches == 0 && pending_views.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
